### rtl/buddy_pkg.sv
package buddy_pkg;

  localparam int MAX_LEVELS  = 11;
  localparam int NODE_COUNT  = (1 << MAX_LEVELS) - 1;
  localparam int ADDR_W      = $clog2(NODE_COUNT);
  localparam int CHUNK_W     = MAX_LEVELS - 1;
  localparam int USED_W      = MAX_LEVELS;
  localparam int LEV_W       = 4;
  localparam int BYTES_W     = 32;
  localparam int CHUNK_BYTES = 1024;
  localparam int CB_SHIFT    = $clog2(CHUNK_BYTES);
  localparam int KB_W        = BYTES_W - CB_SHIFT;
  localparam int NLOG_W      = $clog2(KB_W + 1);
  localparam int STATUS_W    = 2;

  typedef enum logic [1:0] {
    MARK_FREE  = 2'd0,
    MARK_USED  = 2'd1,
    MARK_SPLIT = 2'd2,
    MARK_RSVD  = 2'd3
  } mark_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC   = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_FREED   = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;

  localparam logic KIND_ALLOC = 1'b0;

  // ceil(log2(kb)), zero and one give zero
  function automatic logic [NLOG_W-1:0] ceil_log2(input logic [KB_W-1:0] kb);
    logic [KB_W-1:0]   v;
    logic [NLOG_W-1:0] r;
    v = kb - KB_W'(1);
    r = '0;
    if (kb > KB_W'(1)) begin
      for (int i = 0; i < KB_W; i++) begin
        if (v[i]) r = NLOG_W'(i + 1);
      end
    end
    return r;
  endfunction

endpackage

### rtl/buddy_allocator_tree_core.sv
// flow: an allocate reads a node mark at each step, then descends or backtracks; a free reads
//   node marks on the climb from the leaf, then checks each buddy and its parent while merging,
//   and the result is delivered from the done state
// throughput: one request at a time; in_stall is high whenever the state machine is not idle
// reset: a clearing pass writes all 2047 node marks free, no requests taken;
//   each cfg write restarts the same pass and zeroes the used count
module buddy_allocator_tree_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [buddy_pkg::LEV_W-1:0]         cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_kind,
  input  logic [buddy_pkg::BYTES_W-1:0]       in_request_bytes,
  input  logic [buddy_pkg::CHUNK_W-1:0]       in_free_chunk,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [buddy_pkg::STATUS_W-1:0]      out_status,
  output logic [buddy_pkg::CHUNK_W-1:0]       out_block_chunk,
  output logic [buddy_pkg::USED_W-1:0]        out_used_chunks
);
  import buddy_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_AREQ, S_AEVAL, S_ADOWN, S_BACK,
    S_FREQ, S_FEVAL, S_SREQ, S_SEVAL, S_PREQ, S_PEVAL, S_DONE
  } state_t;

  state_t                 state_r;
  logic [LEV_W-1:0]       levels_r;
  logic [USED_W-1:0]      used_r;
  logic [ADDR_W-1:0]      clr_r;
  logic [ADDR_W-1:0]      pos_r;
  logic [ADDR_W-1:0]      addr_r;
  logic [LEV_W-1:0]       h_r;
  logic [CHUNK_W-1:0]     off_r;
  logic [NLOG_W-1:0]      nlog_r;
  status_t                res_status_r;
  logic [CHUNK_W-1:0]     res_chunk_r;
  logic                   out_valid_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic [CHUNK_W-1:0]     out_chunk_r;
  logic [USED_W-1:0]      out_used_r;

  logic [1:0]             mem [NODE_COUNT];
  logic [1:0]             rd_r;
  logic                   we;
  logic [ADDR_W-1:0]      wa;
  logic [1:0]             wd;

  logic [LEV_W-1:0]       lv_eff;
  logic [LEV_W-1:0]       top_h;
  logic [NLOG_W-1:0]      in_nlog;
  logic [ADDR_W-1:0]      leaf_base;
  logic [ADDR_W-1:0]      left_child;
  logic [ADDR_W-1:0]      parent;
  logic [ADDR_W-1:0]      sibling;
  logic [ADDR_W-1:0]      psibling;
  logic [USED_W-1:0]      cap;
  logic                   accept;

  always_comb begin
    if (levels_r == '0) lv_eff = LEV_W'(1);
    else if (levels_r > LEV_W'(MAX_LEVELS)) lv_eff = LEV_W'(MAX_LEVELS);
    else lv_eff = levels_r;
  end

  assign top_h      = lv_eff - LEV_W'(1);
  assign in_nlog    = ceil_log2(in_request_bytes[BYTES_W-1:CB_SHIFT]);
  assign leaf_base  = (ADDR_W'(1) << top_h) - ADDR_W'(1);
  assign left_child = {pos_r[ADDR_W-2:0], 1'b1};
  assign parent     = (pos_r - ADDR_W'(1)) >> 1;
  assign sibling    = pos_r[0] ? pos_r + ADDR_W'(1) : pos_r - ADDR_W'(1);
  assign psibling   = parent[0] ? parent + ADDR_W'(1) : parent - ADDR_W'(1);
  assign cap        = USED_W'(1) << h_r;
  assign in_stall   = (state_r != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_block_chunk = out_chunk_r;
  assign out_used_chunks = out_used_r;

  always_comb begin
    we = 1'b0;
    wa = pos_r;
    wd = MARK_FREE;
    unique case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        wa = clr_r;
      end
      S_AEVAL: begin
        if (rd_r == MARK_FREE) begin
          we = 1'b1;
          wd = (h_r == LEV_W'(nlog_r)) ? MARK_USED : MARK_SPLIT;
        end
      end
      S_ADOWN: begin
        we = 1'b1;
        wd = (h_r == LEV_W'(nlog_r)) ? MARK_USED : MARK_SPLIT;
      end
      S_FEVAL: begin
        if (!(rd_r == MARK_FREE && pos_r != '0) && rd_r == MARK_USED) we = 1'b1;
      end
      S_PEVAL: begin
        if (rd_r == MARK_SPLIT) begin
          we = 1'b1;
          wa = parent;
        end
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      levels_r    <= LEV_W'(MAX_LEVELS);
      used_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) out_valid_r <= 1'b0;
      if (cfg_we) begin
        levels_r <= cfg_wdata;
        used_r   <= '0;
        clr_r    <= '0;
        state_r  <= S_CLEAR;
      end else begin
        unique case (state_r)
          S_CLEAR: begin
            clr_r <= clr_r + ADDR_W'(1);
            if (clr_r == ADDR_W'(NODE_COUNT - 1)) state_r <= S_IDLE;
          end
          S_IDLE: begin
            if (accept) begin
              if (in_kind == KIND_ALLOC) begin
                h_r    <= top_h;
                nlog_r <= in_nlog;
                pos_r  <= '0;
                addr_r <= '0;
                off_r  <= '0;
                if (in_nlog > NLOG_W'(top_h)) begin
                  res_status_r <= ST_NOSPACE;
                  res_chunk_r  <= '0;
                  state_r      <= S_DONE;
                end else begin
                  state_r <= S_AREQ;
                end
              end else begin
                res_chunk_r <= in_free_chunk;
                if (ADDR_W'(in_free_chunk) >= (ADDR_W'(1) << top_h)) begin
                  res_status_r <= ST_BADFREE;
                  state_r      <= S_DONE;
                end else begin
                  pos_r   <= leaf_base + ADDR_W'(in_free_chunk);
                  addr_r  <= leaf_base + ADDR_W'(in_free_chunk);
                  h_r     <= '0;
                  off_r   <= in_free_chunk;
                  state_r <= S_FREQ;
                end
              end
            end
          end
          S_AREQ: state_r <= S_AEVAL;
          S_AEVAL, S_ADOWN: begin
            if (state_r == S_ADOWN || rd_r == MARK_FREE) begin
              if (h_r == LEV_W'(nlog_r)) begin
                used_r       <= used_r + cap;
                res_status_r <= ST_ALLOC;
                res_chunk_r  <= off_r;
                state_r      <= S_DONE;
              end else begin
                pos_r   <= left_child;
                h_r     <= h_r - LEV_W'(1);
                state_r <= S_ADOWN;
              end
            end else if (rd_r == MARK_SPLIT && h_r > LEV_W'(nlog_r)) begin
              pos_r   <= left_child;
              addr_r  <= left_child;
              h_r     <= h_r - LEV_W'(1);
              state_r <= S_AREQ;
            end else begin
              state_r <= S_BACK;
            end
          end
          S_BACK: begin
            if (pos_r == '0) begin
              res_status_r <= ST_NOSPACE;
              res_chunk_r  <= '0;
              state_r      <= S_DONE;
            end else if (pos_r[0]) begin
              pos_r   <= pos_r + ADDR_W'(1);
              addr_r  <= pos_r + ADDR_W'(1);
              off_r   <= off_r + cap[CHUNK_W-1:0];
              state_r <= S_AREQ;
            end else begin
              pos_r <= parent;
              h_r   <= h_r + LEV_W'(1);
              off_r <= off_r & ~cap[CHUNK_W-1:0];
            end
          end
          S_FREQ: state_r <= S_FEVAL;
          S_FEVAL: begin
            if (rd_r == MARK_FREE && pos_r != '0) begin
              pos_r   <= parent;
              addr_r  <= parent;
              h_r     <= h_r + LEV_W'(1);
              off_r   <= off_r & ~cap[CHUNK_W-1:0];
              state_r <= S_FREQ;
            end else if (rd_r == MARK_USED) begin
              used_r       <= used_r - cap;
              res_status_r <= ST_FREED;
              res_chunk_r  <= off_r;
              addr_r       <= sibling;
              state_r      <= (pos_r == '0) ? S_DONE : S_SREQ;
            end else begin
              res_status_r <= ST_BADFREE;
              state_r      <= S_DONE;
            end
          end
          S_SREQ: state_r <= S_SEVAL;
          S_SEVAL: begin
            if (rd_r == MARK_FREE) begin
              addr_r  <= parent;
              state_r <= S_PREQ;
            end else begin
              state_r <= S_DONE;
            end
          end
          S_PREQ: state_r <= S_PEVAL;
          S_PEVAL: begin
            if (rd_r == MARK_SPLIT) begin
              pos_r   <= parent;
              addr_r  <= psibling;
              h_r     <= h_r + LEV_W'(1);
              state_r <= (parent == '0) ? S_DONE : S_SREQ;
            end else begin
              state_r <= S_DONE;
            end
          end
          S_DONE: begin
            if (!out_valid_r || !out_stall) begin
              out_valid_r  <= 1'b1;
              out_status_r <= res_status_r;
              out_chunk_r  <= res_chunk_r;
              out_used_r   <= used_r;
              state_r      <= S_IDLE;
            end
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

endmodule

### tb/sv/buddy_allocator_tree_core_test.sv
`timescale 1ns / 100ps

module buddy_allocator_tree_core_test;
  import buddy_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 5_000_000;

  typedef struct {
    status_t           status;
    logic [CHUNK_W-1:0] chunk;
    logic [USED_W-1:0]  used;
  } alloc_result_t;

  class buddy_scoreboard;
    mark_t         marks[NODE_COUNT];
    int unsigned   used_count;
    int unsigned   height;
    int unsigned   found_chunk;
    alloc_result_t pending_results[$];
    int unsigned   live_blocks[$];
    int            errors;

    function new();
      errors = 0;
      reconfigure(4'd11);
    endfunction

    function void reconfigure(logic [LEV_W-1:0] v);
      foreach (marks[i]) marks[i] = MARK_FREE;
      used_count = 0;
      height = (v < 1) ? 1 : (v > MAX_LEVELS) ? MAX_LEVELS : v;
      live_blocks.delete();
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function int unsigned level_of(int unsigned pos);
      int unsigned lv;
      int unsigned v;
      lv = 0;
      v = pos + 1;
      while (v != 0) begin
        lv++;
        v >>= 1;
      end
      return lv;
    endfunction

    function bit take_node(int unsigned pos, int unsigned lv, longint unsigned need);
      int unsigned cap;
      if (pos >= (1 << height) - 1 || lv > height) return 0;
      cap = 1 << (height - lv);
      if (cap < need) return 0;
      if (marks[pos] == MARK_FREE) begin
        if (cap / 2 >= need) begin
          if (take_node(2 * pos + 1, lv + 1, need) || take_node(2 * pos + 2, lv + 1, need)) begin
            marks[pos] = MARK_SPLIT;
            return 1;
          end
        end
        marks[pos] = MARK_USED;
        used_count += cap;
        found_chunk = (pos - ((1 << (lv - 1)) - 1)) * cap;
        return 1;
      end
      if (marks[pos] == MARK_SPLIT) begin
        if (cap / 2 < need) return 0;
        if (take_node(2 * pos + 1, lv + 1, need)) return 1;
        return take_node(2 * pos + 2, lv + 1, need);
      end
      return 0;
    endfunction

    function void note_request(logic kind, logic [BYTES_W-1:0] bytes,
                               logic [CHUNK_W-1:0] req);
      alloc_result_t r;
      longint unsigned kb;
      longint unsigned need;
      int unsigned pos;
      int unsigned lv;
      int unsigned cap;
      int unsigned par;
      if (kind == KIND_ALLOC) begin
        kb = bytes >> CB_SHIFT;
        need = 1;
        while (need < kb) need <<= 1;
        if (take_node(0, 1, need)) begin
          r.status = ST_ALLOC;
          r.chunk = CHUNK_W'(found_chunk);
          live_blocks.push_back(found_chunk);
        end else begin
          r.status = ST_NOSPACE;
          r.chunk = '0;
        end
      end else begin
        r.status = ST_BADFREE;
        r.chunk = req;
        if (req < (1 << (height - 1))) begin
          pos = (1 << (height - 1)) - 1 + req;
          while (pos > 0 && marks[pos] == MARK_FREE) pos = (pos - 1) / 2;
          if (marks[pos] == MARK_USED) begin
            lv = level_of(pos);
            cap = 1 << (height - lv);
            marks[pos] = MARK_FREE;
            used_count -= cap;
            r.chunk = CHUNK_W'((pos - ((1 << (lv - 1)) - 1)) * cap);
            r.status = ST_FREED;
            foreach (live_blocks[i]) begin
              if (live_blocks[i] == r.chunk) begin
                live_blocks.delete(i);
                break;
              end
            end
            while (pos > 0) begin
              par = (pos - 1) / 2;
              if (marks[par] == MARK_SPLIT && marks[2 * par + 1] == MARK_FREE &&
                  marks[2 * par + 2] == MARK_FREE) begin
                marks[par] = MARK_FREE;
                pos = par;
              end else begin
                break;
              end
            end
          end
        end
      end
      r.used = USED_W'(used_count);
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [CHUNK_W-1:0] chunk,
                               logic [USED_W-1:0] used);
      alloc_result_t e;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: status %0d chunk %0d used %0d", status, chunk, used);
        return;
      end
      e = pending_results.pop_front();
      if (status !== e.status || chunk !== e.chunk || used !== e.used) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected status %0d chunk %0d used %0d, got %0d %0d %0d",
                   e.status, e.chunk, e.used, status, chunk, used);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [LEV_W-1:0]    cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic                in_kind;
  logic [BYTES_W-1:0]  in_request_bytes;
  logic [CHUNK_W-1:0]  in_free_chunk;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [CHUNK_W-1:0]  out_block_chunk;
  logic [USED_W-1:0]   out_used_chunks;

  buddy_scoreboard sb;
  int unsigned     idle_pct;
  int unsigned     stall_pct;
  int unsigned     hold_cycles;
  int unsigned     cycle_count;

  buddy_allocator_tree_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_request_bytes (in_request_bytes),
    .in_free_chunk    (in_free_chunk),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_block_chunk  (out_block_chunk),
    .out_used_chunks  (out_used_chunks)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("buddy_allocator_tree_core: mismatch");
      $finish;
    end
  end

  // result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_block_chunk, out_used_chunks);
  end

  // receiver stall, with long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_request(logic kind, logic [BYTES_W-1:0] bytes, logic [CHUNK_W-1:0] req);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_request_bytes <= bytes;
    in_free_chunk    <= req;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_request(kind, bytes, req);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_height(logic [LEV_W-1:0] v);
    drain();
    repeat (20) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.reconfigure(v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_request();
    int unsigned r;
    int unsigned s;
    logic [BYTES_W-1:0] bytes;
    r = $urandom_range(99);
    if (r < 45) begin
      s = $urandom_range(9);
      if (s < 7) bytes = $urandom_range(0, 8192);
      else if (s < 9) bytes = $urandom_range(0, 1 << 20);
      else bytes = $urandom;
      send_request(KIND_ALLOC, bytes, '0);
    end else if (r < 85 && sb.live_blocks.size() != 0) begin
      s = sb.live_blocks[$urandom_range(0, sb.live_blocks.size() - 1)];
      send_request(!KIND_ALLOC, $urandom, CHUNK_W'(s + $urandom_range(0, 1)));
    end else begin
      send_request(!KIND_ALLOC, $urandom, CHUNK_W'($urandom_range(0, 1023)));
    end
  endtask

  initial begin
    logic [LEV_W-1:0] heights[6];
    sb = new();
    cycle_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_kind = KIND_ALLOC;
    in_request_bytes = '0;
    in_free_chunk = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_request(KIND_ALLOC, 32'd2048, '0);
    send_request(KIND_ALLOC, 32'd0, '0);
    send_request(KIND_ALLOC, 32'd5000, '0);
    send_request(!KIND_ALLOC, '0, 10'd1);
    send_request(!KIND_ALLOC, '0, 10'd1);
    send_request(!KIND_ALLOC, '0, 10'd2);
    send_request(!KIND_ALLOC, '0, 10'd5);
    send_request(!KIND_ALLOC, '0, 10'd4);
    send_request(KIND_ALLOC, 32'd1048576, '0);
    send_request(KIND_ALLOC, 32'd0, '0);
    send_request(!KIND_ALLOC, '0, 10'd700);
    send_request(KIND_ALLOC, 32'd1048577, '0);
    send_request(KIND_ALLOC, 32'hFFFF_FFFF, '0);
    send_request(KIND_ALLOC, 32'd1023, '0);
    send_request(KIND_ALLOC, 32'd1025, '0);
    send_request(!KIND_ALLOC, '0, 10'd1023);
    send_request(!KIND_ALLOC, '0, 10'd0);

    heights = '{4'd11, 4'd1, 4'd3, 4'd0, 4'd15, 4'd5};
    for (int p = 0; p < 6; p++) begin
      if (p != 0) write_height(heights[p]);
      unique case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      if (p == 4) hold_cycles = 3000;
      for (int i = 0; i < 200; i++) random_request();
    end
    write_height(4'd11);
    idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < 30; i++) random_request();

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("buddy_allocator_tree_core: match");
    end else begin
      $display("buddy_allocator_tree_core: mismatch");
    end
    $finish;
  end

endmodule

### buddy_allocator_tree_core.f
rtl/buddy_pkg.sv
rtl/buddy_allocator_tree_core.sv
tb/sv/buddy_allocator_tree_core_test.sv
